>>> design/fixed_huffman_inflate_assert.svh
// Assertion macros for the fixed Huffman inflater checker.
// Included by fhi_checker.sv; no other dependencies.
`ifndef FIXED_HUFFMAN_INFLATE_ASSERT_SVH
`define FIXED_HUFFMAN_INFLATE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FHI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhi: implication check failed");

// Next-cycle implication, disabled during reset.
`define FHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhi: next-cycle check failed");

`endif

>>> design/fhi_pkg.sv
// Package for the fixed Huffman inflater: item types, phase and state codes,
// deflate length and distance tables. No dependencies.
`timescale 1ns / 1ps

package fhi_pkg;

    localparam int WINDOW_SIZE_DEF = 32768;
    localparam int OUT_LANES_DEF   = 8;
    localparam int MAX_RES         = 33;

    typedef struct packed {
        logic [7:0] comp_byte;
        logic       stream_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last_of_run;
        logic        block_done;
        logic [1:0]  error_code;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_ZHDR = 4'd0,
        PH_DICT = 4'd1,
        PH_BHDR = 4'd2,
        PH_SYM  = 4'd3,
        PH_DIST = 4'd4,
        PH_DONE = 4'd5,
        PH_ERR  = 4'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FIN,
        ST_FLUSH
    } t_state;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_SYMBOL = 2'd2;
    localparam logic [1:0] ERR_DIST   = 2'd3;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        case (idx)
            5'd0:  len_base = 9'd3;    5'd1:  len_base = 9'd4;
            5'd2:  len_base = 9'd5;    5'd3:  len_base = 9'd6;
            5'd4:  len_base = 9'd7;    5'd5:  len_base = 9'd8;
            5'd6:  len_base = 9'd9;    5'd7:  len_base = 9'd10;
            5'd8:  len_base = 9'd11;   5'd9:  len_base = 9'd13;
            5'd10: len_base = 9'd15;   5'd11: len_base = 9'd17;
            5'd12: len_base = 9'd19;   5'd13: len_base = 9'd23;
            5'd14: len_base = 9'd27;   5'd15: len_base = 9'd31;
            5'd16: len_base = 9'd35;   5'd17: len_base = 9'd43;
            5'd18: len_base = 9'd51;   5'd19: len_base = 9'd59;
            5'd20: len_base = 9'd67;   5'd21: len_base = 9'd83;
            5'd22: len_base = 9'd99;   5'd23: len_base = 9'd115;
            5'd24: len_base = 9'd131;  5'd25: len_base = 9'd163;
            5'd26: len_base = 9'd195;  5'd27: len_base = 9'd227;
            5'd28: len_base = 9'd258;
            default: len_base = 9'd0;
        endcase
    endfunction

    function automatic logic [2:0] len_extra(input logic [4:0] idx);
        if (idx >= 5'd8 && idx <= 5'd27) begin
            len_extra = 3'((idx - 5'd4) >> 2);
        end else begin
            len_extra = 3'd0;
        end
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] c);
        case (c)
            5'd0:  dist_base = 16'd1;     5'd1:  dist_base = 16'd2;
            5'd2:  dist_base = 16'd3;     5'd3:  dist_base = 16'd4;
            5'd4:  dist_base = 16'd5;     5'd5:  dist_base = 16'd7;
            5'd6:  dist_base = 16'd9;     5'd7:  dist_base = 16'd13;
            5'd8:  dist_base = 16'd17;    5'd9:  dist_base = 16'd25;
            5'd10: dist_base = 16'd33;    5'd11: dist_base = 16'd49;
            5'd12: dist_base = 16'd65;    5'd13: dist_base = 16'd97;
            5'd14: dist_base = 16'd129;   5'd15: dist_base = 16'd193;
            5'd16: dist_base = 16'd257;   5'd17: dist_base = 16'd385;
            5'd18: dist_base = 16'd513;   5'd19: dist_base = 16'd769;
            5'd20: dist_base = 16'd1025;  5'd21: dist_base = 16'd1537;
            5'd22: dist_base = 16'd2049;  5'd23: dist_base = 16'd3073;
            5'd24: dist_base = 16'd4097;  5'd25: dist_base = 16'd6145;
            5'd26: dist_base = 16'd8193;  5'd27: dist_base = 16'd12289;
            5'd28: dist_base = 16'd16385; 5'd29: dist_base = 16'd24577;
            default: dist_base = 16'd0;
        endcase
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] c);
        if (c >= 5'd2 && c <= 5'd29) begin
            dist_extra = 4'((c - 5'd2) >> 1);
        end else begin
            dist_extra = 4'd0;
        end
    endfunction

    // Huffman codes are stored MSB first in an LSB-first stream
    function automatic logic [8:0] rev9(input logic [8:0] v);
        for (int i = 0; i < 9; i++) begin
            rev9[i] = v[8 - i];
        end
    endfunction

endpackage

>>> design/fixed_huffman_inflate.sv
// Timing: a header byte is accepted on its own; a data byte is accepted, then each decoded
// symbol, length or distance takes a decode step, each copied byte passes a read state and
// a write state, and the run closes through the finish and flush states, all subject to
// output stalls. One item at a time: the input stalls until the run has closed; a copied
// byte takes a read and a write state because the history memory read is registered.
// Reset: synchronous, active low; clears decoder state, history contents are not cleared.
`timescale 1ns / 1ps

module fixed_huffman_inflate #(
    parameter int WINDOW_SIZE = fhi_pkg::WINDOW_SIZE_DEF,
    parameter int OUT_LANES   = fhi_pkg::OUT_LANES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fhi_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fhi_pkg::t_out_item  o_out
);
    import fhi_pkg::*;

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int BWW = $clog2(WINDOW_SIZE + 1);

    // history window
    logic [7:0]    mem [WINDOW_SIZE];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_hbl, n_hbl;
    logic [31:0]   r_buf, n_buf;
    logic [5:0]    r_held, n_held;
    logic [8:0]    r_ml, n_ml;
    logic [BWW-1:0] r_bw, n_bw;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_src, n_src;
    logic [8:0]    r_cnt, n_cnt;
    logic [63:0]   r_lane, n_lane;
    logic [3:0]    r_lane_n, n_lane_n;
    logic [5:0]    r_nres, n_nres;
    logic [1:0]    r_err, n_err;
    logic          r_done, n_done;
    t_out_item     r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    t_out_item     r_out, n_out;
    logic          r_out_v, n_out_v;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= mem_wdata;
        end
        r_rd_data <= mem[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_ZHDR;
            r_hbl    <= 3'd2;
            r_buf    <= '0;
            r_held   <= '0;
            r_ml     <= '0;
            r_bw     <= '0;
            r_wp     <= '0;
            r_lane_n <= '0;
            r_nres   <= '0;
            r_err    <= ERR_NONE;
            r_done   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_hbl    <= n_hbl;
            r_buf    <= n_buf;
            r_held   <= n_held;
            r_ml     <= n_ml;
            r_bw     <= n_bw;
            r_wp     <= n_wp;
            r_lane_n <= n_lane_n;
            r_nres   <= n_nres;
            r_err    <= n_err;
            r_done   <= n_done;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
        r_src  <= n_src;
        r_cnt  <= n_cnt;
        r_lane <= n_lane;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_comb begin
        logic        out_free;
        logic        do_emit, do_put, blocked;
        logic [7:0]  e_byte;
        logic [63:0] e_lane;
        logic [3:0]  e_n;
        logic        e_put;
        t_out_item   put_item;
        logic [4:0]  hc;
        logic [8:0]  rv;
        logic [6:0]  c7;
        logic [7:0]  c8;
        logic [8:0]  c9;
        logic [4:0]  c5;
        logic [8:0]  sym;
        logic [4:0]  slen;
        logic        have_sym;
        logic [4:0]  idx;
        logic [2:0]  leb;
        logic [3:0]  deb;
        logic [15:0] dist_val;
        logic [16:0] src_w;
        logic [BWW-1:0] wp_inc;

        n_state  = r_state;
        n_phase  = r_phase;
        n_hbl    = r_hbl;
        n_buf    = r_buf;
        n_held   = r_held;
        n_ml     = r_ml;
        n_bw     = r_bw;
        n_wp     = r_wp;
        n_src    = r_src;
        n_cnt    = r_cnt;
        n_lane   = r_lane;
        n_lane_n = r_lane_n;
        n_nres   = r_nres;
        n_err    = r_err;
        n_done   = r_done;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_out_v  = r_out_v && i_out_stall;
        mem_we    = 1'b0;
        mem_wdata = '0;

        out_free = !r_out_v || !i_out_stall;
        do_emit  = 1'b0;
        do_put   = 1'b0;
        hc       = '0;

        // one decoded byte: history write, lane append, full group becomes a result
        e_byte  = (r_state == ST_COPY_WR) ? r_rd_data : sym_byte(r_buf);
        e_lane  = r_lane | (64'(e_byte) << {r_lane_n[2:0], 3'b000});
        e_n     = r_lane_n + 4'd1;
        e_put   = (e_n >= 4'(OUT_LANES)) && (r_nres < 6'(MAX_RES));
        blocked = (e_n >= 4'(OUT_LANES)) && e_put && r_hold_v && !out_free;

        // symbol decode from the bit buffer
        rv = rev9(r_buf[8:0]);
        c9 = rv;
        c8 = rv[8:1];
        c7 = rv[8:2];
        rv = rev9({4'd0, r_buf[4:0]});
        c5 = rv[8:4];
        sym      = '0;
        slen     = 5'd7;
        have_sym = 1'b0;
        if (r_held >= 6'd7) begin
            if (c7 <= 7'h17) begin
                sym = 9'd256 + 9'(c7);
                have_sym = 1'b1;
            end else if (r_held >= 6'd8) begin
                slen = 5'd8;
                if (c8 >= 8'h30 && c8 <= 8'hBF) begin
                    sym = 9'(c8 - 8'h30);
                    have_sym = 1'b1;
                end else if (c8 >= 8'hC0 && c8 <= 8'hC7) begin
                    sym = 9'd280 + 9'(c8 - 8'hC0);
                    have_sym = 1'b1;
                end else if (r_held >= 6'd9) begin
                    slen = 5'd9;
                    sym = 9'd144 + (c9 - 9'h190);
                    have_sym = 1'b1;
                end
            end
        end
        idx  = 5'(sym - 9'd257);
        leb  = len_extra(idx);
        deb  = dist_extra(c5);
        dist_val = dist_base(c5) + 16'((r_buf >> 5) & ((32'd1 << deb) - 32'd1));
        src_w = ({1'b0, 16'(r_wp)} >= {1'b0, dist_val})
              ? {1'b0, 16'(r_wp)} - {1'b0, dist_val}
              : {1'b0, 16'(r_wp)} + 17'(WINDOW_SIZE) - {1'b0, dist_val};
        put_item = '{out_bytes: r_lane, byte_count: r_lane_n, last_of_run: 1'b0,
                     block_done: 1'b0, error_code: ERR_NONE};

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.stream_start) begin
                        n_phase = PH_ZHDR;
                        n_hbl   = 3'd2;
                        n_buf   = '0;
                        n_held  = '0;
                        n_ml    = '0;
                        n_bw    = '0;
                        n_wp    = '0;
                    end
                    case (n_phase)
                        PH_ZHDR: begin
                            if (n_hbl >= 3'd2) begin
                                n_hbl = 3'd1;
                            end else if (i_in.comp_byte[5]) begin
                                n_hbl   = 3'd4;
                                n_phase = PH_DICT;
                            end else begin
                                n_hbl   = 3'd0;
                                n_phase = PH_BHDR;
                            end
                        end
                        PH_DICT: begin
                            if (n_hbl != 3'd0) begin
                                n_hbl = n_hbl - 3'd1;
                            end
                            if (n_hbl == 3'd0) begin
                                n_phase = PH_BHDR;
                            end
                        end
                        PH_BHDR, PH_SYM, PH_DIST: begin
                            hc = (n_held > 6'd24) ? 5'd24 : 5'(n_held);
                            n_buf    = n_buf | (32'(i_in.comp_byte) << hc);
                            n_held   = 6'(hc) + 6'd8;
                            n_lane   = '0;
                            n_lane_n = '0;
                            n_nres   = '0;
                            n_err    = ERR_NONE;
                            n_done   = 1'b0;
                            n_state  = ST_DEC;
                        end
                        default: ;
                    endcase
                end
            end

            ST_DEC: begin
                case (r_phase)
                    PH_BHDR: begin
                        if (r_held < 6'd3) begin
                            n_state = ST_FIN;
                        end else begin
                            n_buf  = r_buf >> 3;
                            n_held = r_held - 6'd3;
                            if (r_buf[2:0] != 3'b011) begin
                                n_err   = ERR_HEADER;
                                n_phase = PH_ERR;
                                n_state = ST_FIN;
                            end else begin
                                n_phase = PH_SYM;
                            end
                        end
                    end
                    PH_SYM: begin
                        if (!have_sym) begin
                            n_state = ST_FIN;
                        end else if (sym < 9'd256) begin
                            if (!blocked) begin
                                do_emit = 1'b1;
                                n_buf   = r_buf >> slen;
                                n_held  = r_held - 6'(slen);
                            end
                        end else if (sym == 9'd256) begin
                            n_buf   = r_buf >> slen;
                            n_held  = r_held - 6'(slen);
                            n_done  = 1'b1;
                            n_phase = PH_DONE;
                            n_state = ST_FIN;
                        end else if (sym > 9'd285) begin
                            n_buf   = r_buf >> slen;
                            n_held  = r_held - 6'(slen);
                            n_err   = ERR_SYMBOL;
                            n_phase = PH_ERR;
                            n_state = ST_FIN;
                        end else if (r_held < 6'(slen) + 6'(leb)) begin
                            n_state = ST_FIN;
                        end else begin
                            n_ml = len_base(idx)
                                 + 9'((r_buf >> slen) & ((32'd1 << leb) - 32'd1));
                            n_buf   = r_buf >> (slen + 5'(leb));
                            n_held  = r_held - 6'(slen) - 6'(leb);
                            n_phase = PH_DIST;
                        end
                    end
                    PH_DIST: begin
                        if (r_held < 6'd5) begin
                            n_state = ST_FIN;
                        end else if (c5 >= 5'd30) begin
                            n_buf   = r_buf >> 5;
                            n_held  = r_held - 6'd5;
                            n_err   = ERR_SYMBOL;
                            n_phase = PH_ERR;
                            n_state = ST_FIN;
                        end else if (r_held < 6'd5 + 6'(deb)) begin
                            n_state = ST_FIN;
                        end else begin
                            n_buf  = r_buf >> (5'd5 + 5'(deb));
                            n_held = r_held - 6'd5 - 6'(deb);
                            if (dist_val > 16'(r_bw)) begin
                                n_err   = ERR_DIST;
                                n_phase = PH_ERR;
                                n_state = ST_FIN;
                            end else begin
                                n_src   = src_w[AW-1:0];
                                n_cnt   = r_ml;
                                n_phase = PH_SYM;
                                n_state = ST_COPY_RD;
                            end
                        end
                    end
                    default: n_state = ST_FIN;
                endcase
            end

            ST_COPY_RD: begin
                n_state = ST_COPY_WR;
            end

            ST_COPY_WR: begin
                if (!blocked) begin
                    do_emit = 1'b1;
                    n_src   = (32'(r_src) + 32'd1 == 32'(WINDOW_SIZE)) ? '0 : r_src + 1'b1;
                    n_cnt   = r_cnt - 9'd1;
                    n_state = (r_cnt <= 9'd1) ? ST_DEC : ST_COPY_RD;
                end
            end

            ST_FIN: begin
                if ((r_lane_n != 4'd0 || ((r_err != ERR_NONE || r_done) && r_nres == 6'd0))
                        && r_nres < 6'(MAX_RES)) begin
                    if (!r_hold_v || out_free) begin
                        do_put  = 1'b1;
                        n_state = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out             = r_hold;
                    n_out.last_of_run = 1'b1;
                    n_out.block_done  = r_done;
                    n_out.error_code  = r_err;
                    n_out_v           = 1'b1;
                    n_hold_v          = 1'b0;
                    n_state           = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (do_emit) begin
            mem_we    = 1'b1;
            mem_wdata = e_byte;
            n_wp      = (32'(r_wp) + 32'd1 == 32'(WINDOW_SIZE)) ? '0 : r_wp + 1'b1;
            wp_inc    = r_bw + 1'b1;
            n_bw      = (32'(r_bw) < 32'(WINDOW_SIZE)) ? wp_inc : r_bw;
            if (e_n >= 4'(OUT_LANES)) begin
                n_lane   = '0;
                n_lane_n = '0;
                put_item.out_bytes  = e_lane;
                put_item.byte_count = e_n;
                do_put = e_put;
            end else begin
                n_lane   = e_lane;
                n_lane_n = e_n;
            end
        end else begin
            wp_inc = '0;
        end

        // results pass through a holding stage so the last one can take the flags
        if (do_put) begin
            if (r_hold_v) begin
                n_out   = r_hold;
                n_out_v = 1'b1;
            end
            n_hold   = put_item;
            n_hold_v = 1'b1;
            n_nres   = r_nres + 6'd1;
            if (r_state == ST_FIN) begin
                n_lane   = '0;
                n_lane_n = '0;
            end
        end
    end

    function automatic logic [7:0] sym_byte(input logic [31:0] b);
        logic [8:0] r;
        logic [7:0] cc8;
        logic [8:0] cc9;
        r   = rev9(b[8:0]);
        cc8 = r[8:1];
        cc9 = r;
        if (cc8 >= 8'h30 && cc8 <= 8'hBF) begin
            sym_byte = cc8 - 8'h30;
        end else begin
            sym_byte = 8'((cc9 - 9'h190) + 9'd144);
        end
    endfunction

endmodule

>>> design/fhi_checker.sv
// Port-level checker for the fixed Huffman inflater, bound to the top level.
// Depends on fhi_pkg and fixed_huffman_inflate_assert.svh.
`timescale 1ns / 1ps

`include "fixed_huffman_inflate_assert.svh"

module fhi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fhi_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fhi_pkg::t_out_item o_out
);
    import fhi_pkg::*;

    `FHI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    `FHI_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_out_valid && o_out.byte_count == 4'd0, o_out.last_of_run)
    `FHI_ASSERT_IMPL(a_flags_on_last, i_clk, i_rst_n, o_out_valid && (o_out.error_code != ERR_NONE || o_out.block_done), o_out.last_of_run)
    `FHI_ASSERT_IMPL(a_mid_full, i_clk, i_rst_n, o_out_valid && !o_out.last_of_run, o_out.byte_count != 4'd0 && o_out.error_code == ERR_NONE)

endmodule

bind fixed_huffman_inflate fhi_checker u_fhi_checker (.*);
